/* rtl/core/mdag_pkg.sv */
// ----------------------------------------------------------------------------
// mdag_pkg
// Shared types and constants of the array address generator: table sizes,
// stream field widths, command codes and the queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package mdag_pkg;

   // Descriptor table sizes
   localparam int NUM_ARRAYS = 64;
   localparam int MAX_DIMS   = 16;
   localparam int ID_W       = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
   localparam int DIM_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int SLOT_W     = ID_W + DIM_W;
   localparam int CNT_W      = $clog2(MAX_DIMS + 1);

   // Fixed item field widths
   localparam int ARRAY_ID_W = 6;
   localparam int DIM_NUM_W  = 4;
   localparam int BASE_W     = 31;
   localparam int ELEM_W     = 16;
   localparam int WORD_W     = 32;

   // Stream payload widths (data widths padded to whole bytes)
   localparam int REQ_DATA_W = 160;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Command codes on tuser
   typedef enum logic [1:0] {
      CMD_HEADER = 2'd0,
      CMD_BOUNDS = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   // Work kinds handed to the back end
   typedef enum logic [1:0] {
      OP_HEADER,
      OP_BOUNDS,
      OP_QUERY
   } op_type;

   // One queued job
   //   word_a: base (header), lower bound (bounds), subscript (query)
   //   word_b: element size (header), extent (bounds)
   typedef struct packed {
      op_type                  op;
      logic [ARRAY_ID_W-1:0]   id;
      logic [DIM_W-1:0]        dim;
      logic [WORD_W-1:0]       word_a;
      logic [WORD_W-1:0]       word_b;
      logic                    last;
   } job_type;

   // Back-end control states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_SCALE,
      ST_ADDR
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/mdag_front.sv */
// ----------------------------------------------------------------------------
// mdag_front
// Input side: unpacks a request item, classifies the command, drops unused
// codes and out-of-range dimensions, and forms the dimension extent.
// ----------------------------------------------------------------------------
`default_nettype none

module mdag_front (
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [mdag_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [mdag_pkg::REQ_USER_W-1:0]    req_tuser,
   input  wire logic                               req_tlast,
   output logic                                    push_valid,
   input  wire logic                               push_ready,
   output mdag_pkg::job_type                       push_job
);

   logic [mdag_pkg::ARRAY_ID_W-1:0] array_id;
   logic [mdag_pkg::DIM_NUM_W-1:0]  dim_number;
   logic [mdag_pkg::BASE_W-1:0]     base_addr;
   logic [mdag_pkg::ELEM_W-1:0]     elem_bytes;
   logic [mdag_pkg::WORD_W-1:0]     lo_bound;
   logic [mdag_pkg::WORD_W-1:0]     hi_bound;
   logic [mdag_pkg::WORD_W-1:0]     index_value;
   logic                            keep;

   // Field unpacking, lowest field first
   assign array_id     = req_tdata[5:0];
   assign dim_number   = req_tdata[9:6];
   assign base_addr    = req_tdata[40:10];
   assign elem_bytes   = req_tdata[56:41];
   assign lo_bound     = req_tdata[88:57];
   assign hi_bound     = req_tdata[120:89];
   assign index_value  = req_tdata[152:121];

   // Classify and build the queue entry
   always_comb begin
      keep            = 1'b0;
      push_job.op     = mdag_pkg::OP_QUERY;
      push_job.id     = array_id;
      push_job.dim    = mdag_pkg::DIM_W'(dim_number);
      push_job.word_a = index_value;
      push_job.word_b = '0;
      push_job.last   = req_tlast;
      case (mdag_pkg::cmd_type'(req_tuser))
         mdag_pkg::CMD_HEADER: begin
            keep            = 1'b1;
            push_job.op     = mdag_pkg::OP_HEADER;
            push_job.word_a = {1'b0, base_addr};
            push_job.word_b = {{(mdag_pkg::WORD_W - mdag_pkg::ELEM_W){1'b0}}, elem_bytes};
         end
         mdag_pkg::CMD_BOUNDS: begin
            keep            = (32'(dim_number) < 32'(mdag_pkg::MAX_DIMS));
            push_job.op     = mdag_pkg::OP_BOUNDS;
            push_job.word_a = lo_bound;
            push_job.word_b = hi_bound - lo_bound + 32'd1;
         end
         mdag_pkg::CMD_QUERY: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // Dropped items are consumed as soon as the queue could take one
   assign req_tready = push_ready;
   assign push_valid = req_tvalid && keep;

endmodule

`default_nettype wire

/* rtl/core/mdag_queue.sv */
// ----------------------------------------------------------------------------
// mdag_queue
// Short job FIFO that decouples the input side from the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mdag_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire mdag_pkg::job_type  push_job,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output mdag_pkg::job_type       pop_job
);

   mdag_pkg::job_type                  slots_ff [mdag_pkg::QUEUE_DEPTH];
   logic [mdag_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [mdag_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [mdag_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign push_ready = (count_ff != mdag_pkg::QCNT_W'(mdag_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == mdag_pkg::QPTR_W'(mdag_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == mdag_pkg::QPTR_W'(mdag_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/mdag_back.sv */
// ----------------------------------------------------------------------------
// mdag_back
// Table engine: holds the descriptor memories, runs the per-subscript
// multiply-accumulate and forms the final byte address.
// ----------------------------------------------------------------------------
`default_nettype none

module mdag_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               pop_valid,
   output logic                                    pop_ready,
   input  wire mdag_pkg::job_type                  pop_job,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [mdag_pkg::RSP_DATA_W-1:0]         rsp_tdata
);

   // Descriptor memories
   logic [mdag_pkg::WORD_W-1:0] base_mem   [mdag_pkg::NUM_ARRAYS];
   logic [mdag_pkg::ELEM_W-1:0] elem_mem   [mdag_pkg::NUM_ARRAYS];
   logic [mdag_pkg::WORD_W-1:0] lower_mem  [mdag_pkg::NUM_ARRAYS * mdag_pkg::MAX_DIMS];
   logic [mdag_pkg::WORD_W-1:0] extent_mem [mdag_pkg::NUM_ARRAYS * mdag_pkg::MAX_DIMS];

   mdag_pkg::state_type               state_ff, state_in;
   logic                              do_pop;
   logic                              load_out;
   logic [mdag_pkg::ID_W-1:0]         row;
   logic [mdag_pkg::SLOT_W-1:0]       wr_slot;
   logic [mdag_pkg::SLOT_W-1:0]       rd_slot;

   // Memory read data
   logic [mdag_pkg::WORD_W-1:0]       base_rd_ff;
   logic [mdag_pkg::ELEM_W-1:0]       elem_rd_ff;
   logic [mdag_pkg::WORD_W-1:0]       lower_rd_ff;
   logic [mdag_pkg::WORD_W-1:0]       ext_rd_ff;

   // Query datapath
   logic [mdag_pkg::WORD_W-1:0]       index_ff;
   logic [mdag_pkg::ARRAY_ID_W-1:0]   qid_ff;
   logic                              last_ff;
   logic                              in_range_ff;
   logic [mdag_pkg::WORD_W-1:0]       prod_ff;
   logic [mdag_pkg::WORD_W-1:0]       diff_ff;
   logic [mdag_pkg::WORD_W-1:0]       scaled_ff;
   logic [mdag_pkg::WORD_W-1:0]       acc_ff, acc_in;
   logic [mdag_pkg::CNT_W-1:0]        cnt_ff, cnt_in;

   // Result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mdag_pkg::WORD_W-1:0]       rsp_addr_ff;
   logic [mdag_pkg::ARRAY_ID_W-1:0]   rsp_id_ff;

   assign row     = pop_job.id[mdag_pkg::ID_W-1:0];
   assign wr_slot = {row, pop_job.dim};
   assign rd_slot = {row, cnt_ff[mdag_pkg::DIM_W-1:0]};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mdag_pkg::ST_IDLE: begin
            if (pop_valid && pop_job.op == mdag_pkg::OP_QUERY) begin
               state_in = mdag_pkg::ST_MUL;
            end
         end
         mdag_pkg::ST_MUL:   state_in = mdag_pkg::ST_ACC;
         mdag_pkg::ST_ACC:   state_in = last_ff ? mdag_pkg::ST_SCALE : mdag_pkg::ST_IDLE;
         mdag_pkg::ST_SCALE: state_in = mdag_pkg::ST_ADDR;
         mdag_pkg::ST_ADDR: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = mdag_pkg::ST_IDLE;
            end
         end
         default:            state_in = mdag_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      pop_ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         mdag_pkg::ST_IDLE: pop_ready = 1'b1;
         mdag_pkg::ST_ADDR: load_out  = !rsp_valid_ff || rsp_tready;
         default: begin
            pop_ready = 1'b0;
            load_out  = 1'b0;
         end
      endcase
   end

   assign do_pop = pop_valid && pop_ready;

   // Accumulator and subscript counter
   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (state_ff == mdag_pkg::ST_ACC && in_range_ff) begin
         acc_in = prod_ff + diff_ff;
         cnt_in = cnt_ff + 1'b1;
      end
      if (load_out) begin
         acc_in = '0;
         cnt_in = '0;
      end
   end

   // Result valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdag_pkg::ST_IDLE;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Descriptor writes
   always_ff @(posedge clock) begin
      if (do_pop && pop_job.op == mdag_pkg::OP_HEADER) begin
         base_mem[row] <= pop_job.word_a;
         elem_mem[row] <= pop_job.word_b[mdag_pkg::ELEM_W-1:0];
      end
      if (do_pop && pop_job.op == mdag_pkg::OP_BOUNDS) begin
         lower_mem[wr_slot]  <= pop_job.word_a;
         extent_mem[wr_slot] <= pop_job.word_b;
      end
   end

   // Descriptor reads, registered
   always_ff @(posedge clock) begin
      if (do_pop) begin
         base_rd_ff  <= base_mem[row];
         elem_rd_ff  <= elem_mem[row];
         lower_rd_ff <= lower_mem[rd_slot];
         ext_rd_ff   <= extent_mem[rd_slot];
         index_ff    <= pop_job.word_a;
         qid_ff      <= pop_job.id;
         last_ff     <= pop_job.last;
         in_range_ff <= (32'(cnt_ff) < 32'(mdag_pkg::MAX_DIMS));
      end
   end

   // Datapath stages: multiply, scale, final add
   always_ff @(posedge clock) begin
      if (state_ff == mdag_pkg::ST_MUL) begin
         prod_ff <= acc_ff * ext_rd_ff;
         diff_ff <= index_ff - lower_rd_ff;
      end
      if (state_ff == mdag_pkg::ST_SCALE) begin
         scaled_ff <= acc_ff * {{(mdag_pkg::WORD_W - mdag_pkg::ELEM_W){1'b0}}, elem_rd_ff};
      end
      if (load_out) begin
         rsp_addr_ff <= base_rd_ff + scaled_ff;
         rsp_id_ff   <= qid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mdag_pkg::RSP_DATA_W - mdag_pkg::WORD_W - mdag_pkg::ARRAY_ID_W){1'b0}},
                        rsp_id_ff, rsp_addr_ff};

endmodule

`default_nettype wire

/* rtl/core/multidim_array_address_generator_core.sv */
// Sequence: for each subscript the table words are read, then multiplied and
// accumulated; a final subscript is then scaled and added to the base, waiting
// while a stalled result is not taken. Header and bounds items only write the
// tables. The engine takes no item during a subscript; a 2-entry queue buffers input.
// Reset: synchronous, active high; clears queue, accumulator, counter and result
// valid. Descriptor tables are not cleared and must be written before use.
// ----------------------------------------------------------------------------
// multidim_array_address_generator_core
// Row-major address generator over a table of multidimensional array
// descriptors, with a stream request channel and a stream result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module multidim_array_address_generator_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // array_id[5:0], dim_number[9:6], base addr[40:10], elem_bytes[56:41],
   // lower bound[88:57], upper bound[120:89], index_value[152:121], zero pad
   input  wire logic [mdag_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd[1:0]
   input  wire logic [mdag_pkg::REQ_USER_W-1:0]    req_tuser,
   // last_index
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // byte_address[31:0], query_array[37:32], zero pad
   output logic [mdag_pkg::RSP_DATA_W-1:0]         rsp_tdata
);

   logic               push_valid;
   logic               push_ready;
   mdag_pkg::job_type  push_job;
   logic               pop_valid;
   logic               pop_ready;
   mdag_pkg::job_type  pop_job;

   mdag_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   mdag_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   mdag_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* rtl/core/mdag_checker.sv */
// ----------------------------------------------------------------------------
// mdag_checker
// Port-level checks on the address generator: reset behavior, result
// stability under stall and result padding.
// ----------------------------------------------------------------------------
`default_nettype none

module mdag_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic [mdag_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [mdag_pkg::REQ_USER_W-1:0]    req_tuser,
   input  wire logic                               req_tlast,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [mdag_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // No result straight out of reset
   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Queue is empty after reset, so the input side is ready
   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Padding above query_array is zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[mdag_pkg::RSP_DATA_W-1:38] == '0)
      else $error("result padding not zero");

endmodule

bind multidim_array_address_generator_core mdag_checker u_mdag_checker (.*);

`default_nettype wire
